[rtl/pli_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pli_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths on the stream ports
  localparam int VAL_W       = 32;
  localparam int POS_W       = 5;
  localparam int CNT_OUT_W   = 5;
  localparam int FUNC_W      = 3;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_POS = 3'd0,
    FN_INS_END = 3'd1,
    FN_DEL_POS = 3'd2,
    FN_DEL_END = 3'd3,
    FN_LIST    = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_LIST,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[rtl/positional_list_insert_delete_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to DEPTH words held in a simple dual-port RAM (one write,
// one registered read per cycle). One input word is handled at a time.
// Insert and delete move every entry behind the position by one place, one
// entry per cycle through the RAM; insert or delete at the end moves nothing.
// List all streams one element per cycle while out_tready stays high; a full
// output register stalls the stream until it is taken. The output register
// lets a finished result wait while the next word is taken. No clearing pass
// is needed after reset.
module positional_list_insert_delete_top #(
  parameter int DEPTH      = pli_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = pli_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [31:0] value, [36:32] position, rest zero
  input  wire logic [pli_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [2:0] func
  input  wire logic [pli_pkg::FUNC_W-1:0]         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [31:0] element, [36:32] element_count, rest zero
  output logic      [pli_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic      [pli_pkg::STAT_W-1:0]         out_tuser,
  output logic                                    out_tlast
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PW   = pli_pkg::POS_W;
  localparam int VW   = pli_pkg::VAL_W;
  localparam int CO   = pli_pkg::CNT_OUT_W;
  localparam int CMPW = ((CW > PW) ? CW : PW) + 1;
  localparam int PADW = pli_pkg::OUT_TDATA_W - VW - CO;

  pli_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          left_r, left_nxt;
  logic [AW-1:0]          ptr_r, ptr_nxt;
  logic [AW-1:0]          wa_r, wa_nxt;
  logic [AW-1:0]          idx_r, idx_nxt;
  logic                   ins_r, ins_nxt;
  logic [DATA_WIDTH-1:0]  val_r, val_nxt;
  pli_pkg::stat_t         st_r, st_nxt;
  logic                   pend_r, pend_nxt;
  logic                   rlast_r, rlast_nxt;

  logic                   out_valid_r;
  logic [VW-1:0]          out_elem_r;
  logic                   out_last_r;
  logic [CO-1:0]          out_cnt_r;
  pli_pkg::stat_t         out_st_r;

  logic                   out_free;
  logic                   out_load;
  logic [VW-1:0]          o_elem;
  logic                   o_last;
  logic [CO-1:0]          o_cnt;
  pli_pkg::stat_t         o_st;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [DATA_WIDTH-1:0]  ram_wdata;
  logic                   ram_re;
  logic [DATA_WIDTH-1:0]  rd_data;

  logic [CMPW-1:0]        pos_x;
  logic [CMPW-1:0]        cnt_x;
  logic                   full;
  pli_pkg::func_t         func;

  assign pos_x    = CMPW'(in_tdata[VW +: PW]);
  assign cnt_x    = CMPW'(cnt_r);
  assign full     = (cnt_r == CW'(DEPTH));
  assign func     = pli_pkg::func_t'(in_tuser);
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == pli_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PADW{1'b0}}, out_cnt_r, out_elem_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  pli_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (rd_data)
  );

  // Shifts read one entry and write the previously read one two places away,
  // so a read never hits an entry still waiting for its write.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    ptr_nxt   = ptr_r;
    wa_nxt    = wa_r;
    idx_nxt   = idx_r;
    ins_nxt   = ins_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    pend_nxt  = pend_r;
    rlast_nxt = rlast_r;
    ram_we    = 1'b0;
    ram_waddr = wa_r;
    ram_wdata = rd_data;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    o_elem    = '0;
    o_last    = 1'b1;
    o_cnt     = CO'(cnt_r);
    o_st      = st_r;

    unique case (state_r)
      pli_pkg::S_IDLE: begin
        if (in_tvalid) begin
          val_nxt   = DATA_WIDTH'(in_tdata[VW-1:0]);
          st_nxt    = pli_pkg::STAT_OK;
          state_nxt = pli_pkg::S_DONE;
          unique case (func)
            pli_pkg::FN_INS_POS: begin
              if (full) begin
                st_nxt = pli_pkg::STAT_FULL;
              end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                st_nxt = pli_pkg::STAT_INVALID;
              end else begin
                ins_nxt   = 1'b1;
                idx_nxt   = AW'(pos_x - 1'b1);
                ptr_nxt   = AW'(cnt_x - 1'b1);
                left_nxt  = CW'(cnt_x + 1'b1 - pos_x);
                state_nxt = pli_pkg::S_SHIFT;
              end
            end
            pli_pkg::FN_INS_END: begin
              if (full) begin
                st_nxt = pli_pkg::STAT_FULL;
              end else begin
                ins_nxt   = 1'b1;
                idx_nxt   = AW'(cnt_r);
                left_nxt  = '0;
                state_nxt = pli_pkg::S_SHIFT;
              end
            end
            pli_pkg::FN_DEL_POS: begin
              if (cnt_r == '0) begin
                st_nxt = pli_pkg::STAT_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                st_nxt = pli_pkg::STAT_INVALID;
              end else begin
                ins_nxt   = 1'b0;
                ptr_nxt   = AW'(pos_x);
                left_nxt  = CW'(cnt_x - pos_x);
                state_nxt = pli_pkg::S_SHIFT;
              end
            end
            pli_pkg::FN_DEL_END: begin
              if (cnt_r == '0) begin
                st_nxt = pli_pkg::STAT_EMPTY;
              end else begin
                ins_nxt   = 1'b0;
                left_nxt  = '0;
                state_nxt = pli_pkg::S_SHIFT;
              end
            end
            pli_pkg::FN_LIST: begin
              if (cnt_r == '0) begin
                st_nxt = pli_pkg::STAT_EMPTY;
              end else begin
                ptr_nxt   = '0;
                left_nxt  = cnt_r;
                pend_nxt  = 1'b0;
                state_nxt = pli_pkg::S_LIST;
              end
            end
            default: begin
              // unused codes: no-op, ok status
            end
          endcase
        end
      end

      pli_pkg::S_SHIFT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = rd_data;
        end
        if (left_r != '0) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          wa_nxt   = ins_r ? ptr_r + 1'b1 : ptr_r - 1'b1;
          ptr_nxt  = ins_r ? ptr_r - 1'b1 : ptr_r + 1'b1;
          left_nxt = left_r - 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (ins_r) begin
              ram_we    = 1'b1;
              ram_waddr = idx_r;
              ram_wdata = val_r;
              cnt_nxt   = cnt_r + 1'b1;
            end else begin
              cnt_nxt   = cnt_r - 1'b1;
            end
            o_cnt = CO'(cnt_nxt);
            if (out_free) begin
              out_load  = 1'b1;
              state_nxt = pli_pkg::S_IDLE;
            end else begin
              state_nxt = pli_pkg::S_DONE;
            end
          end
        end
      end

      pli_pkg::S_LIST: begin
        if (pend_r && out_free) begin
          out_load = 1'b1;
          o_elem   = VW'(rd_data);
          o_last   = rlast_r;
          o_st     = pli_pkg::STAT_OK;
          pend_nxt = 1'b0;
          if (rlast_r) begin
            state_nxt = pli_pkg::S_IDLE;
          end
        end
        if (left_r != '0 && (!pend_r || out_free)) begin
          ram_re    = 1'b1;
          pend_nxt  = 1'b1;
          rlast_nxt = (left_r == CW'(1));
          ptr_nxt   = ptr_r + 1'b1;
          left_nxt  = left_r - 1'b1;
        end
      end

      pli_pkg::S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = pli_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pli_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pli_pkg::S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_load | (out_valid_r & ~out_tready);
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    ptr_r   <= ptr_nxt;
    wa_r    <= wa_nxt;
    idx_r   <= idx_nxt;
    ins_r   <= ins_nxt;
    val_r   <= val_nxt;
    st_r    <= st_nxt;
    rlast_r <= rlast_nxt;
    if (out_load) begin
      out_elem_r <= o_elem;
      out_last_r <= o_last;
      out_cnt_r  <= o_cnt;
      out_st_r   <= o_st;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_cnt_only_on_shift: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != pli_pkg::S_SHIFT |=> cnt_r == $past(cnt_r))
    else $error("count changed outside an insert or delete");

  a_write_only_on_shift: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == pli_pkg::S_SHIFT)
    else $error("RAM written outside an insert or delete");

  a_list_word_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> state_r == pli_pkg::S_LIST)
    else $error("non-final word outside list all");

endmodule
`default_nettype wire

[rtl/pli_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module pli_ram #(
  parameter int DEPTH      = pli_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = pli_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_WIDTH-1:0]    wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb_positional_list_insert_delete_top.sv]
`timescale 1ns / 1ps
module tb_positional_list_insert_delete_top;

  localparam int LIST_DEPTH  = pli_pkg::DEPTH_DEF;
  localparam int ITEM_WORDS  = 130;
  localparam int VAL_W       = pli_pkg::VAL_W;
  localparam int POS_W       = pli_pkg::POS_W;
  localparam int FUNC_W      = pli_pkg::FUNC_W;
  localparam int STAT_W      = pli_pkg::STAT_W;
  localparam int CNT_OUT_W   = pli_pkg::CNT_OUT_W;
  localparam int IN_TDATA_W  = pli_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = pli_pkg::OUT_TDATA_W;
  localparam int PAD_W = IN_TDATA_W - VAL_W - POS_W;
  // func codes the block does not use; they must answer ok with no change
  localparam logic [FUNC_W-1:0] FN_RSVD_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RSVD_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0] fn;
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  pos;
    bit                wait_drain;
  } list_op_t;

  typedef struct {
    logic [VAL_W-1:0]     element;
    logic                 last;
    logic [CNT_OUT_W-1:0] count;
    pli_pkg::stat_t       status;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]      in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  logic                   out_tlast;

  list_op_t     pending_ops[$];
  list_result_t due_results[$];
  logic [VAL_W-1:0] shadow_list[LIST_DEPTH];
  int shadow_len = 0;
  int peak_len = 0;
  int gen_len = 0;
  int total_words = 0;
  int accepted_words = 0;
  int results_predicted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int stat_hits[4] = '{0, 0, 0, 0};
  int hold_left = 0;
  int next_hold_at = 30;

  always #2 clk = ~clk;

  positional_list_insert_delete_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // ---------------- predictor ----------------
  function automatic pli_pkg::stat_t shadow_insert(input int pos,
                                                   input logic [VAL_W-1:0] val);
    if (shadow_len >= LIST_DEPTH) return pli_pkg::STAT_FULL;
    if (pos < 1 || pos > shadow_len + 1) return pli_pkg::STAT_INVALID;
    for (int i = shadow_len; i > pos - 1; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[pos-1] = val;
    shadow_len++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    return pli_pkg::STAT_OK;
  endfunction

  function automatic pli_pkg::stat_t shadow_delete(input int pos);
    if (shadow_len == 0) return pli_pkg::STAT_EMPTY;
    if (pos < 1 || pos > shadow_len) return pli_pkg::STAT_INVALID;
    for (int i = pos - 1; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
    shadow_len--;
    return pli_pkg::STAT_OK;
  endfunction

  task automatic apply_list_op(input logic [FUNC_W-1:0] fn, input logic [VAL_W-1:0] val,
                               input int pos, output int n_out);
    pli_pkg::stat_t st;
    list_result_t r;
    st = pli_pkg::STAT_OK;
    n_out = 1;
    case (fn)
      pli_pkg::FN_INS_POS: st = shadow_insert(pos, val);
      pli_pkg::FN_INS_END: st = shadow_insert(shadow_len + 1, val);
      pli_pkg::FN_DEL_POS: st = shadow_delete(pos);
      pli_pkg::FN_DEL_END:
        st = (shadow_len == 0) ? pli_pkg::STAT_EMPTY : shadow_delete(shadow_len);
      pli_pkg::FN_LIST: begin
        if (shadow_len != 0) begin
          for (int i = 0; i < shadow_len; i++) begin
            r.element = shadow_list[i];
            r.last    = (i + 1 == shadow_len);
            r.count   = CNT_OUT_W'(shadow_len);
            r.status  = pli_pkg::STAT_OK;
            due_results.push_back(r);
          end
          n_out = shadow_len;
          return;
        end
        st = pli_pkg::STAT_EMPTY;
      end
      default: ;
    endcase
    r.element = '0;
    r.last    = 1'b1;
    r.count   = CNT_OUT_W'(shadow_len);
    r.status  = st;
    due_results.push_back(r);
  endtask

  // ---------------- stimulus building ----------------
  function automatic logic [VAL_W-1:0] rand_value();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // tracks only the length so that random positions can be kept in range
  task automatic queue_word(input logic [FUNC_W-1:0] fn, input logic [VAL_W-1:0] val,
                            input int pos, input bit drain);
    list_op_t w;
    w.fn = fn;
    w.value = val;
    w.pos = POS_W'(pos);
    w.wait_drain = drain;
    pending_ops.push_back(w);
    case (fn)
      pli_pkg::FN_INS_POS:
        if (gen_len < LIST_DEPTH && w.pos >= 1 && w.pos <= gen_len + 1) gen_len++;
      pli_pkg::FN_INS_END: if (gen_len < LIST_DEPTH) gen_len++;
      pli_pkg::FN_DEL_POS: if (gen_len > 0 && w.pos >= 1 && w.pos <= gen_len) gen_len--;
      pli_pkg::FN_DEL_END: if (gen_len > 0) gen_len--;
      default: ;
    endcase
  endtask

  task automatic fill_list();
    while (gen_len < LIST_DEPTH) begin
      if ($urandom_range(1))
        queue_word(pli_pkg::FN_INS_END, rand_value(), $urandom_range(31), 1'b0);
      else
        queue_word(pli_pkg::FN_INS_POS, rand_value(), $urandom_range(gen_len + 1, 1), 1'b0);
    end
    queue_word(pli_pkg::FN_INS_POS, rand_value(), $urandom_range(31), 1'b0);
    queue_word(pli_pkg::FN_INS_END, rand_value(), $urandom_range(31), 1'b0);
    queue_word(pli_pkg::FN_LIST, rand_value(), $urandom_range(31), 1'b0);
  endtask

  task automatic empty_list();
    while (gen_len > 0) begin
      if ($urandom_range(1))
        queue_word(pli_pkg::FN_DEL_END, rand_value(), $urandom_range(31), 1'b0);
      else
        queue_word(pli_pkg::FN_DEL_POS, rand_value(), $urandom_range(gen_len, 1), 1'b0);
    end
    queue_word(pli_pkg::FN_DEL_POS, rand_value(), $urandom_range(31), 1'b0);
    queue_word(pli_pkg::FN_DEL_END, rand_value(), $urandom_range(31), 1'b0);
    queue_word(pli_pkg::FN_LIST, rand_value(), $urandom_range(31), 1'b0);
  endtask

  // 0: sender idles 36%, receiver 54%; 1: swapped; 2: no idling
  function automatic int idle_pct(input bit receiver);
    int phase;
    phase = (total_words == 0) ? 0 : accepted_words * 3 / total_words;
    if (phase == 0) return receiver ? 54 : 36;
    if (phase == 1) return receiver ? 36 : 54;
    return 0;
  endfunction

  // ---------------- input driver ----------------
  always @(posedge clk) begin
    int n_new;
    bit took;
    took = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        took = 1'b1;
        apply_list_op(in_tuser, in_tdata[VAL_W-1:0], in_tdata[VAL_W +: POS_W], n_new);
        accepted_words <= accepted_words + 1;
        results_predicted <= results_predicted + n_new;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ops.size() != 0 &&
            !(pending_ops[0].wait_drain && (took || results_predicted != results_seen)) &&
            $urandom_range(99) >= idle_pct(1'b0)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {{PAD_W{1'b0}}, pending_ops[0].pos, pending_ops[0].value};
          in_tuser  <= pending_ops[0].fn;
          void'(pending_ops.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result ready, with long hold-offs ----------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (accepted_words >= next_hold_at) begin
      out_tready <= 1'b0;
      hold_left <= 150;
      next_hold_at <= next_hold_at + 60;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      stat_hits[out_tuser]++;
      if (results_seen >= results_predicted) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing pending: elem %h cnt %0d st %0d last %b",
                   $realtime, out_tdata[VAL_W-1:0], out_tdata[VAL_W +: CNT_OUT_W],
                   out_tuser, out_tlast);
      end else begin
        want = due_results.pop_front();
        if (out_tdata[VAL_W-1:0] !== want.element || out_tlast !== want.last ||
            out_tdata[VAL_W +: CNT_OUT_W] !== want.count || out_tuser !== want.status ||
            out_tdata[OUT_TDATA_W-1:VAL_W+CNT_OUT_W] !== '0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: word %0d exp elem %h last %b cnt %0d st %0d pad 0",
                     $realtime, results_seen, want.element, want.last, want.count,
                     want.status);
            $display("    got elem %h last %b cnt %0d st %0d pad %h",
                     out_tdata[VAL_W-1:0], out_tlast, out_tdata[VAL_W +: CNT_OUT_W],
                     out_tuser, out_tdata[OUT_TDATA_W-1:VAL_W+CNT_OUT_W]);
          end
        end
      end
    end
  end

  // ---------------- stimulus and end of run ----------------
  initial begin
    int pick;
    int target;
    // empty list: list, deletes at any position
    queue_word(pli_pkg::FN_LIST, 32'h0, 0, 1'b0);
    queue_word(pli_pkg::FN_DEL_END, 32'h0, 0, 1'b0);
    queue_word(pli_pkg::FN_DEL_POS, 32'hFFFF_FFFF, 31, 1'b0);
    // insert positions out of range
    queue_word(pli_pkg::FN_INS_POS, 32'h1111_1111, 0, 1'b0);
    queue_word(pli_pkg::FN_INS_POS, 32'h2222_2222, 2, 1'b0);
    // front, end, middle, count+1, front again
    queue_word(pli_pkg::FN_INS_POS, 32'hFFFF_FFFF, 1, 1'b0);
    queue_word(pli_pkg::FN_INS_END, 32'h0000_0000, 31, 1'b0);
    queue_word(pli_pkg::FN_INS_POS, 32'hA5A5_5A5A, 2, 1'b0);
    queue_word(pli_pkg::FN_INS_POS, 32'h0000_1234, 4, 1'b0);
    queue_word(pli_pkg::FN_INS_POS, 32'h5A5A_A5A5, 1, 1'b0);
    // delete positions out of range
    queue_word(pli_pkg::FN_DEL_POS, 32'h0, 0, 1'b0);
    queue_word(pli_pkg::FN_DEL_POS, 32'h0, 6, 1'b0);
    queue_word(pli_pkg::FN_LIST, 32'h0, 0, 1'b0);
    queue_word(FN_RSVD_5, 32'hDEAD_BEEF, 1, 1'b0);
    queue_word(FN_RSVD_6, 32'hFFFF_FFFF, 31, 1'b0);
    queue_word(FN_RSVD_7, 32'h0, 0, 1'b0);
    // delete front, middle, middle again, end
    queue_word(pli_pkg::FN_DEL_POS, 32'h0, 1, 1'b0);
    queue_word(pli_pkg::FN_DEL_POS, 32'h0, 2, 1'b0);
    queue_word(pli_pkg::FN_DEL_POS, 32'h0, 2, 1'b0);
    queue_word(pli_pkg::FN_LIST, 32'h0, 0, 1'b0);
    queue_word(pli_pkg::FN_DEL_END, 32'h0, 0, 1'b0);
    queue_word(pli_pkg::FN_LIST, 32'h0, 0, 1'b0);

    target = ITEM_WORDS;
    queue_word(pli_pkg::FN_LIST, rand_value(), $urandom_range(31), 1'b1);
    fill_list();
    empty_list();
    while (pending_ops.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        fill_list();
      end else if (pick < 9) begin
        empty_list();
      end else if (pick < 60) begin
        // well-formed edit, biased toward the ends of the list
        if (gen_len == 0 || (gen_len < LIST_DEPTH && $urandom_range(99) < 55)) begin
          case ($urandom_range(3))
            0: queue_word(pli_pkg::FN_INS_POS, rand_value(), 1, $urandom_range(24) == 0);
            1: queue_word(pli_pkg::FN_INS_POS, rand_value(), gen_len + 1,
                          $urandom_range(24) == 0);
            2: queue_word(pli_pkg::FN_INS_END, rand_value(), $urandom_range(31),
                          $urandom_range(24) == 0);
            default: queue_word(pli_pkg::FN_INS_POS, rand_value(),
                                $urandom_range(gen_len + 1, 1), $urandom_range(24) == 0);
          endcase
        end else begin
          case ($urandom_range(3))
            0: queue_word(pli_pkg::FN_DEL_POS, rand_value(), 1, $urandom_range(24) == 0);
            1: queue_word(pli_pkg::FN_DEL_POS, rand_value(), gen_len,
                          $urandom_range(24) == 0);
            2: queue_word(pli_pkg::FN_DEL_END, rand_value(), $urandom_range(31),
                          $urandom_range(24) == 0);
            default: queue_word(pli_pkg::FN_DEL_POS, rand_value(),
                                $urandom_range(gen_len, 1), $urandom_range(24) == 0);
          endcase
        end
      end else if (pick < 72) begin
        queue_word(pli_pkg::FN_LIST, rand_value(), $urandom_range(31),
                   $urandom_range(24) == 0);
      end else if (pick < 86) begin
        // out-of-range positions
        if ($urandom_range(1))
          queue_word(pli_pkg::FN_INS_POS, rand_value(),
                     $urandom_range(1) ? 0 : $urandom_range(31, gen_len + 2), 1'b0);
        else
          queue_word(pli_pkg::FN_DEL_POS, rand_value(),
                     $urandom_range(1) ? 0 : $urandom_range(31, gen_len + 1), 1'b0);
      end else begin
        queue_word(FUNC_W'($urandom_range(7)), $urandom, $urandom_range(31),
                   $urandom_range(24) == 0);
      end
    end
    total_words = pending_ops.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_words != total_words) @(posedge clk);
    while (results_seen < results_predicted) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("ran %0d list operations giving %0d result words, list length up to %0d",
             accepted_words, results_seen, peak_len);
    $display("status seen: ok %0d, bad position %0d, full %0d, empty %0d",
             stat_hits[pli_pkg::STAT_OK], stat_hits[pli_pkg::STAT_INVALID],
             stat_hits[pli_pkg::STAT_FULL], stat_hits[pli_pkg::STAT_EMPTY]);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d result failures", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d of %0d words taken, %0d of %0d results seen",
             accepted_words, total_words, results_seen, results_predicted);
    $display("simulation failed");
    $finish;
  end

endmodule
